[rtl/core/rht_pkg.sv]
// Package for the region handle table: sizes, codes, sequencer states.
// No dependencies; imported by region_handle_table_unit.
`timescale 1ns / 1ps

package rht_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned BLOCK_BYTES = 2097152;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned PAGE_BITS   = $clog2(PAGE_BYTES);
  localparam int unsigned BLOCK_BITS  = $clog2(BLOCK_BYTES);

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned POL_W   = 5;
  localparam int unsigned FB_W    = 27;
  localparam int unsigned BC_W    = 28;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [HANDLE_W-1:0] SCRAMBLE_CONST = 32'hFCFD_FEFF;

  localparam logic [ADDR_W-1:0]   RST_WINDOW_START = 48'h0000_4000_0000;
  localparam logic [HANDLE_W-1:0] RST_KEY          = 32'd1;
  localparam logic [HANDLE_W-1:0] RST_FIRST_HANDLE = 32'd100;

  typedef enum logic [1:0] {
    REQ_CREATE  = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_MISALIGNED = 4'd1,
    ST_WINDOW     = 4'd2,
    ST_ROOT       = 4'd3,
    ST_OVERLAP    = 4'd4,
    ST_FULL       = 4'd5,
    ST_EXHAUSTED  = 4'd6,
    ST_UNKNOWN    = 4'd7,
    ST_WRONG_POL  = 4'd8,
    ST_PERMANENT  = 4'd9
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START = 3'd0,
    CFG_WINDOW_END   = 3'd1,
    CFG_KEY          = 3'd2,
    CFG_FIRST_HANDLE = 3'd3,
    CFG_FORBID_ROOT  = 3'd4,
    CFG_ROOT_POLICY  = 3'd5,
    CFG_PERM_MASK    = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_ALLOC,
    S_SPAN,
    S_COUNT,
    S_DONE
  } state_e;

  // Keyed handle scrambling; applying it twice gives the input back.
  function automatic logic [HANDLE_W-1:0] scramble(input logic [HANDLE_W-1:0] h,
                                                   input logic [HANDLE_W-1:0] key);
    return h ^ {key[7:0], key[31:8]} ^ SCRAMBLE_CONST;
  endfunction

endpackage

[rtl/core/region_handle_table_unit.sv]
// Region handle table: create, destroy and query over a small entry table.
// Depends on rht_pkg.
`timescale 1ns / 1ps
//
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------
//  in      | sink      | in_valid_i/in_ready_o, req_type_i..handle_i
//  out     | source    | out_valid_o/out_ready_i, status_o..block_count_o
//  cfg     | sink      | cfg_we_i, cfg_idx_i, cfg_wdata_i (no handshake)
//
// A request steps through a check, a scan of up to ENTRIES entries, one or two
// handle tries for a create, the span and count states and a result state.
// The scan compares one entry per cycle against the request.
// Reset clears all valid bits at once; no clearing pass is needed.
// A result waits in the output register; the next request is taken meanwhile,
// but its result is not loaded until the previous one is transferred.

module region_handle_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rht_pkg::ADDR_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [rht_pkg::ADDR_W-1:0]    address_i,
  input  logic [rht_pkg::ADDR_W-1:0]    length_i,
  input  logic [rht_pkg::POL_W-1:0]     policy_i,
  input  logic [rht_pkg::HANDLE_W-1:0]  handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    status_o,
  output logic [rht_pkg::HANDLE_W-1:0]  new_handle_o,
  output logic                          matched_o,
  output logic [rht_pkg::POL_W-1:0]     found_policy_o,
  output logic [rht_pkg::FB_W-1:0]      first_block_o,
  output logic [rht_pkg::BC_W-1:0]      block_count_o
);
  import rht_pkg::*;

  // configuration
  logic [ADDR_W-1:0]   win_start_q, win_end_q;
  logic [HANDLE_W-1:0] key_q, first_q, perm_q, counter_q, counter_d;
  logic                forbid_q;
  logic [POL_W-1:0]    root_q;

  // entry table
  logic [ENTRIES-1:0]  valid_q;
  logic [ADDR_W-1:0]   ent_start_q [ENTRIES];
  logic [ADDR_W-1:0]   ent_size_q  [ENTRIES];
  logic [POL_W-1:0]    ent_pol_q   [ENTRIES];
  logic [HANDLE_W-1:0] ent_hdl_q   [ENTRIES];
  logic                ent_we, ent_clr;

  // request and sequencer
  state_e              state_q, state_d;
  req_e                req_q, req_d;
  logic [ADDR_W-1:0]   addr_q, addr_d, len_q, len_d;
  logic [POL_W-1:0]    pol_q, pol_d;
  logic [HANDLE_W-1:0] hraw_q, hraw_d, raw_q, raw_d;
  logic [IDX_W-1:0]    idx_q, idx_d, free_idx_q, free_idx_d;
  logic                free_found_q, free_found_d, tries_q, tries_d;
  logic [BC_W-1:0]     fb_q, fb_d, lb_q, lb_d;

  // staged result
  status_e             res_st_q, res_st_d;
  logic [HANDLE_W-1:0] res_hdl_q, res_hdl_d;
  logic                res_match_q, res_match_d;
  logic [POL_W-1:0]    res_pol_q, res_pol_d;
  logic [FB_W-1:0]     res_fb_q, res_fb_d;
  logic [BC_W-1:0]     res_bc_q, res_bc_d;
  logic                out_load;

  // scan datapath: one entry per cycle
  logic [ADDR_W:0]     req_end, ent_end, lb_diff;
  logic [ADDR_W-1:0]   fb_diff;
  logic [HANDLE_W-1:0] scr_next;
  logic                cur_valid, overlap, covers, hdl_hit, last_idx;

  assign req_end  = {1'b0, addr_q} + {1'b0, len_q};
  assign ent_end  = {1'b0, ent_start_q[idx_q]} + {1'b0, ent_size_q[idx_q]};
  assign cur_valid = valid_q[idx_q];
  assign overlap  = ({1'b0, addr_q} < ent_end) && ({1'b0, ent_start_q[idx_q]} < req_end);
  assign covers   = (addr_q >= ent_start_q[idx_q]) && ({1'b0, addr_q} < ent_end);
  assign hdl_hit  = (ent_hdl_q[idx_q] == hraw_q);
  assign last_idx = (idx_q == IDX_W'(ENTRIES - 1));
  assign scr_next = scramble(counter_q, key_q);
  assign fb_diff  = addr_q - win_start_q;
  assign lb_diff  = req_end - {{ADDR_W{1'b0}}, 1'b1} - {1'b0, win_start_q};

  assign in_ready_o = (state_q == S_IDLE);

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    addr_d       = addr_q;
    len_d        = len_q;
    pol_d        = pol_q;
    hraw_d       = hraw_q;
    raw_d        = raw_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    tries_d      = tries_q;
    fb_d         = fb_q;
    lb_d         = lb_q;
    res_st_d     = res_st_q;
    res_hdl_d    = res_hdl_q;
    res_match_d  = res_match_q;
    res_pol_d    = res_pol_q;
    res_fb_d     = res_fb_q;
    res_bc_d     = res_bc_q;
    counter_d    = counter_q;
    ent_we       = 1'b0;
    ent_clr      = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = req_e'(req_type_i);
          addr_d       = address_i;
          len_d        = length_i;
          pol_d        = policy_i;
          hraw_d       = scramble(handle_i, key_q);
          idx_d        = '0;
          free_found_d = 1'b0;
          tries_d      = 1'b0;
          res_st_d     = ST_OK;
          res_hdl_d    = '0;
          res_match_d  = 1'b0;
          res_pol_d    = '0;
          res_fb_d     = '0;
          res_bc_d     = '0;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_SCAN;
        if (req_q == REQ_CREATE) begin
          if (addr_q == '0 || addr_q[PAGE_BITS-1:0] != '0 ||
              len_q == '0 || len_q[PAGE_BITS-1:0] != '0) begin
            res_st_d = ST_MISALIGNED;
            state_d  = S_DONE;
          end else if (addr_q < win_start_q || req_end > {1'b0, win_end_q}) begin
            res_st_d = ST_WINDOW;
            state_d  = S_DONE;
          end else if (forbid_q && pol_q == root_q) begin
            res_st_d = ST_ROOT;
            state_d  = S_DONE;
          end
        end else if (req_q == REQ_NONE) begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        case (req_q)
          REQ_CREATE: begin
            if (cur_valid && overlap) begin
              res_st_d = ST_OVERLAP;
              state_d  = S_DONE;
            end else begin
              if (!cur_valid && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = idx_q;
              end
              if (last_idx) begin
                if (free_found_q || !cur_valid) begin
                  state_d = S_ALLOC;
                end else begin
                  res_st_d = ST_FULL;
                  state_d  = S_DONE;
                end
              end
            end
          end
          REQ_DESTROY: begin
            if (cur_valid && hdl_hit) begin
              state_d = S_DONE;
              if (ent_pol_q[idx_q] != pol_q) begin
                res_st_d = ST_WRONG_POL;
              end else if (perm_q[pol_q]) begin
                res_st_d = ST_PERMANENT;
              end else begin
                ent_clr = 1'b1;
              end
            end else if (last_idx) begin
              res_st_d = ST_UNKNOWN;
              state_d  = S_DONE;
            end
          end
          REQ_QUERY: begin
            if (cur_valid && covers) begin
              res_match_d = 1'b1;
              res_pol_d   = ent_pol_q[idx_q];
              state_d     = S_DONE;
            end else if (last_idx) begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ALLOC: begin
        // take the counter value; skip one that scrambles to zero
        if (counter_q == first_q - 1'b1) begin
          res_st_d = ST_EXHAUSTED;
          state_d  = S_DONE;
        end else begin
          counter_d = counter_q + 1'b1;
          raw_d     = counter_q;
          if (scr_next != '0) begin
            res_hdl_d = scr_next;
            state_d   = S_SPAN;
          end else if (tries_q) begin
            res_st_d = ST_EXHAUSTED;
            state_d  = S_DONE;
          end else begin
            tries_d = 1'b1;
          end
        end
      end
      S_SPAN: begin
        ent_we   = 1'b1;
        fb_d     = BC_W'(fb_diff >> BLOCK_BITS);
        lb_d     = BC_W'(lb_diff >> BLOCK_BITS);
        res_fb_d = FB_W'(fb_diff >> BLOCK_BITS);
        state_d  = S_COUNT;
      end
      S_COUNT: begin
        res_bc_d = lb_q - fb_q + 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a first_handle write also reloads the counter
    if (cfg_we_i && cfg_e'(cfg_idx_i) == CFG_FIRST_HANDLE) begin
      counter_d = cfg_wdata_i[HANDLE_W-1:0];
    end
  end

  // sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= REQ_NONE;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      tries_q      <= 1'b0;
      out_valid_o  <= 1'b0;
      valid_q      <= '0;
      win_start_q  <= RST_WINDOW_START;
      win_end_q    <= '0;
      key_q        <= RST_KEY;
      first_q      <= RST_FIRST_HANDLE;
      counter_q    <= RST_FIRST_HANDLE;
      forbid_q     <= 1'b0;
      root_q       <= '0;
      perm_q       <= '0;
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      tries_q      <= tries_d;
      counter_q    <= counter_d;
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (ent_we) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (ent_clr) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_WINDOW_START: win_start_q <= cfg_wdata_i;
          CFG_WINDOW_END:   win_end_q   <= cfg_wdata_i;
          CFG_KEY:          key_q       <= cfg_wdata_i[HANDLE_W-1:0];
          CFG_FIRST_HANDLE: first_q     <= cfg_wdata_i[HANDLE_W-1:0];
          CFG_FORBID_ROOT:  forbid_q    <= cfg_wdata_i[0];
          CFG_ROOT_POLICY:  root_q      <= cfg_wdata_i[POL_W-1:0];
          CFG_PERM_MASK:    perm_q      <= cfg_wdata_i[HANDLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers and entry table
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    len_q       <= len_d;
    pol_q       <= pol_d;
    hraw_q      <= hraw_d;
    raw_q       <= raw_d;
    free_idx_q  <= free_idx_d;
    fb_q        <= fb_d;
    lb_q        <= lb_d;
    res_st_q    <= res_st_d;
    res_hdl_q   <= res_hdl_d;
    res_match_q <= res_match_d;
    res_pol_q   <= res_pol_d;
    res_fb_q    <= res_fb_d;
    res_bc_q    <= res_bc_d;
    if (ent_we) begin
      ent_start_q[free_idx_q] <= addr_q;
      ent_size_q[free_idx_q]  <= len_q;
      ent_pol_q[free_idx_q]   <= pol_q;
      ent_hdl_q[free_idx_q]   <= raw_q;
    end
    if (out_load) begin
      status_o       <= res_st_q;
      new_handle_o   <= res_hdl_q;
      matched_o      <= res_match_q;
      found_policy_o <= res_pol_q;
      first_block_o  <= res_fb_q;
      block_count_o  <= res_bc_q;
    end
  end

  // failed requests carry no handle or span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> new_handle_o == '0 && block_count_o == '0)
    else $error("failed request reports a handle or span");

  // a query hit is always a successful request without a handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matched_o |-> status_o == ST_OK && new_handle_o == '0)
    else $error("query hit with bad status or handle");

  // allocation only starts with a free entry recorded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC |-> free_found_q)
    else $error("allocation without a free entry");

  // a new result is only loaded into a free or draining output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_o || out_ready_i)
    else $error("result overwritten before transfer");

endmodule

[bench/region_handle_table_unit_tb.sv]
// Self-checking bench for region_handle_table_unit: directed and random requests.
// A predictor inside the bench tracks the table and the config registers.
// Depends on rht_pkg and region_handle_table_unit.
`timescale 1ns / 1ps

module region_handle_table_unit_tb;
  import rht_pkg::*;

  typedef struct {
    req_e                kind;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   len;
    logic [POL_W-1:0]    pol;
    logic [HANDLE_W-1:0] hnd;
  } request_t;

  typedef struct {
    logic [3:0]          status;
    logic [HANDLE_W-1:0] new_handle;
    logic                matched;
    logic [POL_W-1:0]    found_policy;
    logic [FB_W-1:0]     first_block;
    logic [BC_W-1:0]     block_count;
  } outcome_t;

  localparam logic [ADDR_W-1:0] ADDR_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] SPAN_64MB = 48'h0000_0400_0000;
  localparam int unsigned       LATENCY   = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [ADDR_W-1:0]     cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            req_type_i = '0;
  logic [ADDR_W-1:0]     address_i = '0;
  logic [ADDR_W-1:0]     length_i = '0;
  logic [POL_W-1:0]      policy_i = '0;
  logic [HANDLE_W-1:0]   handle_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [3:0]            status_o;
  logic [HANDLE_W-1:0]   new_handle_o;
  logic                  matched_o;
  logic [POL_W-1:0]      found_policy_o;
  logic [FB_W-1:0]       first_block_o;
  logic [BC_W-1:0]       block_count_o;

  region_handle_table_unit uut (.*);

  // Predicted table state and register copies
  logic [ADDR_W-1:0]   win_start;
  logic [ADDR_W-1:0]   win_end;
  logic [HANDLE_W-1:0] key_reg;
  logic [HANDLE_W-1:0] first_reg;
  logic [HANDLE_W-1:0] next_handle;
  logic                forbid_reg;
  logic [POL_W-1:0]    root_reg;
  logic [31:0]         perm_reg;
  logic                slot_valid [ENTRIES];
  logic [ADDR_W-1:0]   slot_start [ENTRIES];
  logic [ADDR_W-1:0]   slot_size  [ENTRIES];
  logic [POL_W-1:0]    slot_pol   [ENTRIES];
  logic [HANDLE_W-1:0] slot_raw   [ENTRIES];

  outcome_t pending_results [$];
  int       mismatches = 0;
  bit       calm = 1'b0;
  int       stall_req = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [HANDLE_W-1:0] mix_handle(logic [HANDLE_W-1:0] h);
    return h ^ {key_reg[7:0], key_reg[31:8]} ^ SCRAMBLE_CONST;
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic outcome_t table_apply(request_t r);
    outcome_t    o;
    logic [63:0] r_end, s, e, fb, lb;
    int          free_idx;
    bit          hit;
    bit          got;
    logic [HANDLE_W-1:0] raw, scr;
    o = '{default: '0};
    case (r.kind)
      REQ_CREATE: begin
        r_end = {16'b0, r.addr} + {16'b0, r.len};
        if (r.addr == 0 || r.addr[PAGE_BITS-1:0] != 0 || r.len == 0 ||
            r.len[PAGE_BITS-1:0] != 0) begin
          o.status = ST_MISALIGNED;
        end else if (r.addr < win_start || r_end > {16'b0, win_end}) begin
          o.status = ST_WINDOW;
        end else if (forbid_reg && r.pol == root_reg) begin
          o.status = ST_ROOT;
        end else begin
          free_idx = -1;
          hit = 1'b0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
              s = {16'b0, slot_start[i]};
              e = s + {16'b0, slot_size[i]};
              if ({16'b0, r.addr} < e && s < r_end) hit = 1'b1;
            end else if (free_idx < 0) begin
              free_idx = i;
            end
          end
          if (hit) o.status = ST_OVERLAP;
          else if (free_idx < 0) o.status = ST_FULL;
          else begin
            got = 1'b0;
            raw = '0;
            scr = '0;
            // a handle that scrambles to zero is skipped once
            for (int t = 0; t < 2; t++) begin
              if (!got && next_handle != first_reg - 1) begin
                raw = next_handle;
                next_handle = next_handle + 1;
                scr = mix_handle(raw);
                if (scr != 0) got = 1'b1;
              end else begin
                t = 2;
              end
            end
            if (!got) o.status = ST_EXHAUSTED;
            else begin
              slot_valid[free_idx] = 1'b1;
              slot_start[free_idx] = r.addr;
              slot_size[free_idx]  = r.len;
              slot_pol[free_idx]   = r.pol;
              slot_raw[free_idx]   = raw;
              fb = ({16'b0, r.addr} - {16'b0, win_start}) >> BLOCK_BITS;
              lb = (r_end - 1 - {16'b0, win_start}) >> BLOCK_BITS;
              o.status      = ST_OK;
              o.new_handle  = scr;
              o.first_block = fb[FB_W-1:0];
              o.block_count = 28'(lb - fb + 1);
            end
          end
        end
      end
      REQ_DESTROY: begin
        raw = mix_handle(r.hnd);
        o.status = ST_UNKNOWN;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && slot_raw[i] == raw) begin
            if (slot_pol[i] != r.pol) o.status = ST_WRONG_POL;
            else if (perm_reg[r.pol]) o.status = ST_PERMANENT;
            else begin
              slot_valid[i] = 1'b0;
              o.status = ST_OK;
            end
            i = ENTRIES;
          end
        end
      end
      REQ_QUERY: begin
        o.status = ST_OK;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && r.addr >= slot_start[i] &&
              {16'b0, r.addr} < {16'b0, slot_start[i]} + {16'b0, slot_size[i]}) begin
            o.matched = 1'b1;
            o.found_policy = slot_pol[i];
            i = ENTRIES;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic request_t make_req(req_e k, logic [ADDR_W-1:0] a,
                                        logic [ADDR_W-1:0] l, logic [POL_W-1:0] p,
                                        logic [HANDLE_W-1:0] h);
    request_t r;
    r.kind = k;
    r.addr = a;
    r.len  = l;
    r.pol  = p;
    r.hnd  = h;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Check each transfer on the output channel against the oldest prediction
  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", status_o, '0);
      end else begin
        w = pending_results.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (new_handle_o !== w.new_handle)
          report_mismatch("new_handle", new_handle_o, w.new_handle);
        if (matched_o !== w.matched) report_mismatch("matched", matched_o, w.matched);
        if (found_policy_o !== w.found_policy)
          report_mismatch("found_policy", found_policy_o, w.found_policy);
        if (first_block_o !== w.first_block)
          report_mismatch("first_block", first_block_o, w.first_block);
        if (block_count_o !== w.block_count)
          report_mismatch("block_count", block_count_o, w.block_count);
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when requested
  always @(negedge clk_i) begin
    int hold_left;
    if (stall_req > 0) begin
      hold_left = stall_req;
      stall_req = 0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Offer one request and hold it until the transfer; called at a falling edge
  task automatic issue(request_t r);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r.kind;
    address_i  <= r.addr;
    length_i   <= r.len;
    policy_i   <= r.pol;
    handle_i   <= r.hnd;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(table_apply(r));
    @(negedge clk_i);
  endtask

  // Drop valid and let every outstanding result drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [ADDR_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_WINDOW_START: win_start = val;
      CFG_WINDOW_END:   win_end = val;
      CFG_KEY:          key_reg = val[31:0];
      CFG_FIRST_HANDLE: begin
        first_reg = val[31:0];
        next_handle = val[31:0];
      end
      CFG_FORBID_ROOT:  forbid_reg = val[0];
      CFG_ROOT_POLICY:  root_reg = val[POL_W-1:0];
      CFG_PERM_MASK:    perm_reg = val[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(logic [ADDR_W-1:0] ws, logic [ADDR_W-1:0] we,
                           logic [31:0] key, logic [31:0] first, logic forbid,
                           logic [POL_W-1:0] root, logic [31:0] perm);
    cfg_write(CFG_WINDOW_START, ws);
    cfg_write(CFG_WINDOW_END, we);
    cfg_write(CFG_KEY, 48'(key));
    cfg_write(CFG_FIRST_HANDLE, 48'(first));
    cfg_write(CFG_FORBID_ROOT, 48'(forbid));
    cfg_write(CFG_ROOT_POLICY, 48'(root));
    cfg_write(CFG_PERM_MASK, 48'(perm));
  endtask

  // Pick a request biased toward live entries so that destroys and queries hit
  function automatic request_t random_request(logic [ADDR_W-1:0] base);
    request_t r;
    int       live [$];
    int       pick, i;
    for (int k = 0; k < ENTRIES; k++) if (slot_valid[k]) live.push_back(k);
    pick = $urandom_range(99);
    r = make_req(REQ_NONE, rand48(), rand48(), 5'($urandom), $urandom);
    if (pick < 40) begin
      r.kind = REQ_CREATE;
      r.addr = base + (48'($urandom_range(0, 16383)) << PAGE_BITS);
      r.len  = 48'($urandom_range(1, 600)) << PAGE_BITS;
      if ($urandom_range(99) < 5) r.addr[PAGE_BITS-1:0] = 12'($urandom);
      if ($urandom_range(99) < 5) r.len[PAGE_BITS-1:0] = 12'($urandom);
    end else if (pick < 70) begin
      r.kind = REQ_DESTROY;
      if (live.size() != 0 && $urandom_range(99) < 85) begin
        i = live[$urandom_range(0, live.size() - 1)];
        r.hnd = mix_handle(slot_raw[i]);
        if ($urandom_range(99) < 80) r.pol = slot_pol[i];
      end
    end else if (pick < 95) begin
      r.kind = REQ_QUERY;
      if (live.size() != 0 && $urandom_range(99) < 80) begin
        i = live[$urandom_range(0, live.size() - 1)];
        r.addr = slot_start[i] + (rand48() % slot_size[i]);
      end else begin
        r.addr = base + (rand48() % SPAN_64MB);
      end
    end else begin
      r.kind = req_e'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic random_phase(int count, logic [ADDR_W-1:0] base, int calm_items,
                              int stall_at, int pause_at);
    for (int n = 0; n < count; n++) begin
      calm = (n < calm_items);
      if (n == stall_at) begin
        @(posedge clk_i);
        stall_req = 300;
        @(negedge clk_i);
      end
      if (n == pause_at) drain();
      issue(random_request(base));
    end
    calm = 1'b0;
    drain();
  endtask

  // Reset register values: empty window, so every aligned create is refused
  task automatic test_reset_state();
    issue(make_req(REQ_CREATE, 48'h0000_4000_0000, 48'h1000, 5'd1, 32'd0));
    issue(make_req(REQ_CREATE, 48'h0, 48'h1000, 5'd1, 32'd0));
    issue(make_req(REQ_CREATE, 48'h0000_4000_0800, 48'h1000, 5'd1, 32'd0));
    issue(make_req(REQ_CREATE, 48'h0000_4000_0000, 48'h0, 5'd1, 32'd0));
    issue(make_req(REQ_CREATE, 48'h0000_4000_0000, 48'h1001, 5'd1, 32'd0));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd31, 32'hFFFF_FFFF));
    issue(make_req(REQ_QUERY, ADDR_MAX, '0, '0, '0));
    issue(make_req(REQ_NONE, ADDR_MAX, ADDR_MAX, 5'd31, 32'hFFFF_FFFF));
    drain();
  endtask

  // Window, root, overlap, full, permanent, wrong-policy and unknown codes, the window edges and a full table
  task automatic test_status_codes();
    logic [ADDR_W-1:0] ws;
    ws = 48'h0000_4000_0000;
    configure(ws, ws + SPAN_64MB, 32'hA5C3_1E77, 32'd100, 1'b1, 5'd0, 32'h0000_0080);
    issue(make_req(REQ_CREATE, ws, 48'h1000, 5'd3, '0));
    issue(make_req(REQ_CREATE, ws, 48'h1000, 5'd4, '0));
    issue(make_req(REQ_CREATE, ws + 48'h10_0000, 48'h1000, 5'd0, '0));
    issue(make_req(REQ_CREATE, ws + SPAN_64MB - 48'h1000, 48'h2000, 5'd3, '0));
    issue(make_req(REQ_CREATE, ws - 48'h1000, 48'h1000, 5'd3, '0));
    issue(make_req(REQ_CREATE, ws + SPAN_64MB - 48'h1000, 48'h1000, 5'd7, '0));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd7, mix_handle(slot_raw[1])));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd8, mix_handle(slot_raw[1])));
    issue(make_req(REQ_QUERY, ws + SPAN_64MB - 1, '0, '0, '0));
    issue(make_req(REQ_QUERY, ws + 48'h1000, '0, '0, '0));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd3, mix_handle(slot_raw[0])));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd3, mix_handle(slot_raw[0])));
    // fill the table with regions that straddle 2 MB blocks, then one more
    for (int i = 0; i < ENTRIES; i++)
      issue(make_req(REQ_CREATE, ws + 48'(i) * 48'h40_0000 + 48'h1F_F000, 48'h2000,
                     5'(i + 1), '0));
    drain();
  endtask

  // Zero-scrambling handle is skipped; a reloaded counter gives duplicate handles
  task automatic test_handle_reuse();
    logic [31:0] zero_raw;
    cfg_write(CFG_PERM_MASK, '0);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) issue(make_req(REQ_DESTROY, '0, '0, slot_pol[i],
                                        mix_handle(slot_raw[i])));
    drain();
    zero_raw = mix_handle(32'd0);
    cfg_write(CFG_FIRST_HANDLE, 48'(zero_raw));
    issue(make_req(REQ_CREATE, win_start + 48'h1000, 48'h1000, 5'd5, '0));
    drain();
    cfg_write(CFG_FIRST_HANDLE, 48'(zero_raw + 1));
    issue(make_req(REQ_CREATE, win_start + 48'h8000, 48'h1000, 5'd6, '0));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd6, mix_handle(zero_raw + 1)));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd5, mix_handle(zero_raw + 1)));
    issue(make_req(REQ_DESTROY, '0, '0, 5'd6, mix_handle(zero_raw + 1)));
    drain();
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] ws;
    ws = 48'h0000_4000_0000;
    configure(ws, ws + SPAN_64MB, $urandom, $urandom, 1'b1, 5'($urandom),
              32'(1) << $urandom_range(0, 31));
    random_phase(600, ws, 150, 300, 450);
    // widest window, all-ones key and counter at the top
    configure('0, ADDR_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd31, 32'h0);
    random_phase(600, {rand48() % (ADDR_MAX - SPAN_64MB)} & ~48'hFFF, 0, 100, -1);
    // window at the top of the address space, every policy permanent
    configure(48'hFFFF_C000_0000, ADDR_MAX, 32'h0, 32'h0, 1'b1, 5'd31, 32'hFFFF_FFFF);
    random_phase(550, 48'hFFFF_FC00_0000, 0, -1, 275);
  endtask

  initial begin
    win_start   = RST_WINDOW_START;
    win_end     = '0;
    key_reg     = RST_KEY;
    first_reg   = RST_FIRST_HANDLE;
    next_handle = RST_FIRST_HANDLE;
    forbid_reg  = 1'b0;
    root_reg    = '0;
    perm_reg    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_start[i] = '0;
      slot_size[i]  = '0;
      slot_pol[i]   = '0;
      slot_raw[i]   = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_status_codes();
    test_handle_reuse();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rht_pkg.sv
rtl/core/region_handle_table_unit.sv
bench/region_handle_table_unit_tb.sv
